@@ hw/rtl/srfzg_pkg.sv @@
// Shared types and constants for the sample record framer.
// Holds request and result codes, counter widths and the controller/datapath structs.
// No dependencies.
`default_nettype none

package srfzg_pkg;

    // Largest record, in samples
    localparam int BLOCK_SAMPLES = 512;
    // Stored-sample counter must hold BLOCK_SAMPLES itself
    localparam int CNT_W = $clog2(BLOCK_SAMPLES + 1);
    // Longest zero run that may be released as samples
    localparam logic [5:0] ZERO_RUN_CAP = 6'd48;

    // Request opcodes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;
    localparam logic [1:0] OP_STREAM = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_STORE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE  = 2'd1;
    localparam logic [1:0] KIND_GAP    = 2'd2;
    localparam logic [1:0] KIND_STREAM = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MAX_ZERO_RUN = 1'b0;
    localparam logic CFG_SCALE_FACTOR = 1'b1;

    // Result item that the datapath builds on an emit command
    localparam logic [2:0] ITEM_STORE_V    = 3'd0;
    localparam logic [2:0] ITEM_STORE_ZERO = 3'd1;
    localparam logic [2:0] ITEM_CLOSE      = 3'd2;
    localparam logic [2:0] ITEM_GAP        = 3'd3;
    localparam logic [2:0] ITEM_STREAM     = 3'd4;

    typedef struct packed {
        logic       load_in;    // capture request and start the multiply
        logic       do_sat;     // register the scaled sample
        logic       zero_inc;   // count one held zero
        logic       emit;       // load the output register
        logic [2:0] item;       // which result to build
        logic       last;       // final result of this request
        logic       mark_load;  // take the new timemark header
    } srfzg_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       v_zero;     // scaled sample is zero
        logic       suppress;   // zero-run suppression enabled
        logic       run_over;   // held run exceeds the limit
        logic       run_nz;     // zeros are held
        logic       run_one;    // exactly one zero held
        logic       count_nz;   // open record holds samples
        logic       will_fill;  // next store fills the record
        logic       pending;    // timemark header waiting
        logic       out_free;   // output register can take a result
    } srfzg_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/srfzg_ctrl.sv @@
// Sequencer for the sample record framer: decides the order of result items.
// Depends on srfzg_pkg for opcodes, item codes and the command/status structs.
`default_nettype none

module srfzg_ctrl
    import srfzg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire srfzg_stat_t stat,
    output srfzg_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE        = 4'd0;
    localparam logic [3:0] S_SAT         = 4'd1;
    localparam logic [3:0] S_DECIDE      = 4'd2;
    localparam logic [3:0] S_CLOSE_PRE   = 4'd3;
    localparam logic [3:0] S_GAP         = 4'd4;
    localparam logic [3:0] S_REL         = 4'd5;
    localparam logic [3:0] S_REL_CLOSE   = 4'd6;
    localparam logic [3:0] S_STORE       = 4'd7;
    localparam logic [3:0] S_STORE_CLOSE = 4'd8;
    localparam logic [3:0] S_FLUSH_CLOSE = 4'd9;
    localparam logic [3:0] S_STREAM      = 4'd10;
    localparam logic [3:0] S_DONE        = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       is_sample;

    assign is_sample = (stat.op == OP_SAMPLE);
    assign in_stall  = (state_reg != S_IDLE);

    // Decide the next step and the command for this cycle
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.item      = ITEM_STREAM;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SAT;
                end
            end
            S_SAT:
            begin
                cmd.do_sat = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (is_sample)
                begin
                    if (stat.suppress && stat.v_zero)
                    begin
                        cmd.zero_inc = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (stat.suppress && stat.run_over)
                        state_next = (stat.count_nz || stat.pending) ? S_CLOSE_PRE : S_GAP;
                    else if (stat.suppress && stat.run_nz)
                        state_next = S_REL;
                    else
                        state_next = S_STORE;
                end
                else
                begin
                    if (stat.suppress && !stat.run_over && stat.run_nz)
                        state_next = S_REL;
                    else if (stat.count_nz)
                        state_next = S_FLUSH_CLOSE;
                    else if (stat.op == OP_STREAM)
                        state_next = S_STREAM;
                    else
                        state_next = S_DONE;
                end
            end
            S_CLOSE_PRE:
            begin
                cmd.item = ITEM_CLOSE;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                cmd.item = ITEM_GAP;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_STORE;
                end
            end
            S_REL:
            begin
                // a released zero is never the final result
                cmd.item = ITEM_STORE_ZERO;
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.will_fill)
                        state_next = S_REL_CLOSE;
                    else if (!stat.run_one)
                        state_next = S_REL;
                    else
                        state_next = is_sample ? S_STORE : S_FLUSH_CLOSE;
                end
            end
            S_REL_CLOSE:
            begin
                cmd.item = ITEM_CLOSE;
                cmd.last = !stat.run_nz && (stat.op == OP_MARK || stat.op == OP_FLUSH);
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.run_nz)
                        state_next = S_REL;
                    else if (is_sample)
                        state_next = S_STORE;
                    else if (stat.op == OP_STREAM)
                        state_next = S_STREAM;
                    else
                        state_next = S_DONE;
                end
            end
            S_STORE:
            begin
                cmd.item = ITEM_STORE_V;
                cmd.last = !stat.will_fill;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.will_fill ? S_STORE_CLOSE : S_IDLE;
                end
            end
            S_STORE_CLOSE:
            begin
                cmd.item = ITEM_CLOSE;
                cmd.last = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH_CLOSE:
            begin
                cmd.item = ITEM_CLOSE;
                cmd.last = (stat.op != OP_STREAM);
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = (stat.op == OP_STREAM) ? S_STREAM : S_DONE;
                end
            end
            S_STREAM:
            begin
                cmd.item = ITEM_STREAM;
                cmd.last = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // a timemark takes effect after its flush
                cmd.mark_load = (stat.op == OP_MARK);
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/srfzg_dp.sv @@
// Datapath of the sample record framer: config, scaler, record state, output register.
// Depends on srfzg_pkg; driven by srfzg_ctrl through the command struct.
`default_nettype none

module srfzg_dp
    import srfzg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire srfzg_cmd_t         cmd,
    output srfzg_stat_t             stat,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] sample_value,
    input  wire logic [63:0]        mark_time_in,
    input  wire logic signed [31:0] usec_correction_in,
    input  wire logic [6:0]         quality_in,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              kind,
    output logic signed [31:0]      sample_out,
    output logic [31:0]             count_out,
    output logic                    has_time,
    output logic [63:0]             time_out,
    output logic signed [31:0]      correction_out,
    output logic [6:0]              quality_out,
    output logic                    last
);

    // Configuration
    logic [6:0]  max_zero_run_reg;
    logic [31:0] scale_factor_reg;

    // Request capture and scaling
    logic [1:0]  op_reg;
    logic [31:0] raw_reg;
    logic [63:0] time_in_reg;
    logic [31:0] corr_in_reg;
    logic [6:0]  qual_in_reg;
    logic [62:0] prod_reg;
    logic [31:0] v_reg;
    logic [31:0] mag_in;
    logic [62:0] prod_next;
    logic [46:0] quot;
    logic        quot_big;
    logic [31:0] v_scaled;
    logic [31:0] v_next;

    // Record state
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      zero_run_reg;
    logic             pending_reg;
    logic [63:0]      mark_time_reg;
    logic [31:0]      mark_corr_reg;
    logic [6:0]       mark_qual_reg;
    logic [5:0]       limit;
    logic [CNT_W-1:0] count_inc;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [31:0] sample_reg;
    logic [31:0] count_out_reg;
    logic        has_time_reg;
    logic [63:0] time_reg;
    logic [31:0] corr_reg;
    logic [6:0]  qual_reg;
    logic        last_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_zero_run_reg <= 7'h7F;
            scale_factor_reg <= 32'hFFFF_0000;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MAX_ZERO_RUN)
                max_zero_run_reg <= cfg_data[6:0];
            else
                scale_factor_reg <= cfg_data;
        end
    end

    // Magnitude of the incoming sample and the gain product
    assign mag_in    = sample_value[31] ? (32'd0 - sample_value) : sample_value;
    assign prod_next = {32'd0, scale_factor_reg[30:0]} * {31'd0, mag_in};

    // Truncate toward zero, then saturate to int32
    assign quot     = prod_reg[62:16];
    assign quot_big = |quot[46:31];
    always_comb
    begin
        if (raw_reg[31])
            v_scaled = quot_big ? 32'h8000_0000 : (32'd0 - quot[31:0]);
        else
            v_scaled = quot_big ? 32'h7FFF_FFFF : quot[31:0];
    end
    assign v_next = scale_factor_reg[31] ? raw_reg : v_scaled;

    // Capture the request, multiply, then register the sample
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= op;
            raw_reg     <= sample_value;
            time_in_reg <= mark_time_in;
            corr_in_reg <= usec_correction_in;
            qual_in_reg <= quality_in;
            prod_reg    <= prod_next;
        end
        if (cmd.do_sat)
            v_reg <= v_next;
    end

    // Zero-run limit, with large settings capped
    assign limit     = (max_zero_run_reg[5:0] > ZERO_RUN_CAP) ? ZERO_RUN_CAP
                                                              : max_zero_run_reg[5:0];
    assign count_inc = count_reg + CNT_W'(1);

    // Update the record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            zero_run_reg  <= '0;
            pending_reg   <= 1'b0;
            mark_time_reg <= '0;
            mark_corr_reg <= '0;
            mark_qual_reg <= '0;
        end
        else if (cmd.mark_load)
        begin
            zero_run_reg  <= '0;
            pending_reg   <= 1'b1;
            mark_time_reg <= time_in_reg;
            mark_corr_reg <= corr_in_reg;
            mark_qual_reg <= qual_in_reg;
        end
        else if (cmd.zero_inc)
        begin
            if (zero_run_reg != 32'hFFFF_FFFF)
                zero_run_reg <= zero_run_reg + 32'd1;
        end
        else if (cmd.emit)
        begin
            case (cmd.item)
                ITEM_STORE_V:
                    count_reg <= count_inc;
                ITEM_STORE_ZERO:
                begin
                    count_reg    <= count_inc;
                    zero_run_reg <= zero_run_reg - 32'd1;
                end
                ITEM_CLOSE:
                begin
                    count_reg   <= '0;
                    pending_reg <= 1'b0;
                end
                ITEM_GAP:
                    zero_run_reg <= '0;
                default:
                begin
                end
            endcase
        end
    end

    // Output register valid: drop on take, set on emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Build the result item
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            last_reg      <= cmd.last;
            sample_reg    <= '0;
            count_out_reg <= '0;
            has_time_reg  <= 1'b0;
            time_reg      <= '0;
            corr_reg      <= '0;
            qual_reg      <= '0;
            case (cmd.item)
                ITEM_STORE_V:
                begin
                    kind_reg      <= KIND_STORE;
                    sample_reg    <= v_reg;
                    count_out_reg <= 32'(count_inc);
                end
                ITEM_STORE_ZERO:
                begin
                    kind_reg      <= KIND_STORE;
                    count_out_reg <= 32'(count_inc);
                end
                ITEM_CLOSE:
                begin
                    kind_reg      <= KIND_CLOSE;
                    count_out_reg <= 32'(count_reg);
                    if (pending_reg)
                    begin
                        has_time_reg <= 1'b1;
                        time_reg     <= mark_time_reg;
                        corr_reg     <= mark_corr_reg;
                        qual_reg     <= mark_qual_reg;
                    end
                end
                ITEM_GAP:
                begin
                    kind_reg      <= KIND_GAP;
                    count_out_reg <= zero_run_reg;
                    corr_reg      <= mark_corr_reg;
                    qual_reg      <= mark_qual_reg;
                end
                default:
                begin
                    kind_reg <= KIND_STREAM;
                end
            endcase
        end
    end

    // Status toward the sequencer
    always_comb
    begin
        stat.op        = op_reg;
        stat.v_zero    = (v_reg == 32'd0);
        stat.suppress  = !max_zero_run_reg[6];
        stat.run_over  = (zero_run_reg > {26'd0, limit});
        stat.run_nz    = (zero_run_reg != 32'd0);
        stat.run_one   = (zero_run_reg == 32'd1);
        stat.count_nz  = (count_reg != '0);
        stat.will_fill = (count_reg >= CNT_W'(BLOCK_SAMPLES - 1));
        stat.pending   = pending_reg;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign sample_out     = sample_reg;
    assign count_out      = count_out_reg;
    assign has_time       = has_time_reg;
    assign time_out       = time_reg;
    assign correction_out = corr_reg;
    assign quality_out    = qual_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sample_record_framer_zero_gap.sv @@
// Top level of the sample record framer: sequencer plus datapath.
// Depends on srfzg_pkg, srfzg_ctrl and srfzg_dp.
`default_nettype none

// Packs signed 32-bit samples into records of up to BLOCK_SAMPLES, with an optional
// Q16.16 gain and zero-run suppression. Every stored sample comes out as a kind 0
// result; record closes, gap items and stream-flush markers follow as the requests
// cause them, and the final result of each request has last set. One request is
// worked at a time: the gain multiply runs in the accepting cycle and saturation in the
// next, then the sequencer decides and emits the results one by one, each while the
// output register is free. Requests other than samples pass through a final done state.
// The next request is accepted while the last result still waits in the output
// register. Configuration is written through cfg_valid/cfg_index/cfg_data; the user
// must write it only while idle, as the block itself does not enforce that.
module sample_record_framer_zero_gap
    import srfzg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] sample_value,
    input  wire logic [63:0]        mark_time_in,
    input  wire logic signed [31:0] usec_correction_in,
    input  wire logic [6:0]         quality_in,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              kind,
    output logic signed [31:0]      sample_out,
    output logic [31:0]             count_out,
    output logic                    has_time,
    output logic [63:0]             time_out,
    output logic signed [31:0]      correction_out,
    output logic [6:0]              quality_out,
    output logic                    last,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data
);

    srfzg_cmd_t  cmd;
    srfzg_stat_t stat;

    // Configuration writes are taken at any time
    assign cfg_ready = 1'b1;

    srfzg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    srfzg_dp u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_we             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .op                 (op),
        .sample_value       (sample_value),
        .mark_time_in       (mark_time_in),
        .usec_correction_in (usec_correction_in),
        .quality_in         (quality_in),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .kind               (kind),
        .sample_out         (sample_out),
        .count_out          (count_out),
        .has_time           (has_time),
        .time_out           (time_out),
        .correction_out     (correction_out),
        .quality_out        (quality_out),
        .last               (last)
    );

`ifndef NO_ASSERTIONS
    // One request at a time: an accepted request holds off the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in progress");

    // Stored-sample counts stay within one record
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STORE |->
            count_out != 32'd0 && count_out <= 32'(BLOCK_SAMPLES))
        else $error("stored sample count out of range");

    // A gap is always followed by the sample that ended it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_GAP |-> !last)
        else $error("gap item marked as final result");

    // The stream flush marker ends its request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STREAM |-> last)
        else $error("stream flush item not marked final");
`endif

endmodule

`default_nettype wire

@@ tb/sample_record_framer_zero_gap_tb.sv @@
// Self-checking testbench for sample_record_framer_zero_gap: directed and randomized requests
// are checked result by result against an in-bench predictor of framing, gain and zero holding.
// Depends on srfzg_pkg and the sample_record_framer_zero_gap RTL.
`default_nettype none

module sample_record_framer_zero_gap_tb;
    import srfzg_pkg::*;

    // Cycles without any accepted request, result or register write before giving up
    localparam int WATCHDOG_CYCLES = 2000;
    // Settle time after the last expected result; a held zero yields nothing to wait on
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 42;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] smp;
        logic [31:0] cnt;
        logic        has;
        logic [63:0] tm;
        logic [31:0] corr;
        logic [6:0]  qual;
        logic        lst;
    } framer_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         op = OP_SAMPLE;
    logic signed [31:0] sample_value = '0;
    logic [63:0]        mark_time_in = '0;
    logic signed [31:0] usec_correction_in = '0;
    logic [6:0]         quality_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         kind;
    logic signed [31:0] sample_out;
    logic [31:0]        count_out;
    logic               has_time;
    logic [63:0]        time_out;
    logic signed [31:0] correction_out;
    logic [6:0]         quality_out;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = CFG_MAX_ZERO_RUN;
    logic [31:0]        cfg_data = '0;

    // Predictor copy of the registers and the framing state
    logic signed [6:0] run_limit_cfg = 7'h7F;
    logic [31:0]       gain_cfg = 32'hFFFF0000;
    int unsigned       rec_count = 0;
    logic [31:0]       held_zeros = '0;
    logic              hdr_pending = 1'b0;
    logic [63:0]       hdr_time = '0;
    logic [31:0]       hdr_corr = '0;
    logic [6:0]        hdr_qual = '0;

    framer_result_t step_results[$];
    framer_result_t expected_results[$];

    int burst_left = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int unexpected_count = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int stall_mode_left = 0;
    int stall_run = 0;

    sample_record_framer_zero_gap u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .op                 (op),
        .sample_value       (sample_value),
        .mark_time_in       (mark_time_in),
        .usec_correction_in (usec_correction_in),
        .quality_in         (quality_in),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .kind               (kind),
        .sample_out         (sample_out),
        .count_out          (count_out),
        .has_time           (has_time),
        .time_out           (time_out),
        .correction_out     (correction_out),
        .quality_out        (quality_out),
        .last               (last),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void push_result(logic [1:0] k, logic [31:0] s, logic [31:0] c,
                                        logic h, logic [63:0] t, logic [31:0] corr,
                                        logic [6:0] q);
        framer_result_t r;
        r = '{kind: k, smp: s, cnt: c, has: h, tm: t, corr: corr, qual: q, lst: 1'b0};
        step_results.push_back(r);
    endfunction

    function automatic logic suppression_on();
        return !run_limit_cfg[6];
    endfunction

    // Only meaningful while suppression is on; values above the cap clamp to it
    function automatic logic [31:0] zero_limit();
        return (run_limit_cfg > 7'sd48) ? 32'd48 : 32'(run_limit_cfg);
    endfunction

    // Q16.16 gain, truncate toward zero, saturate to int32
    function automatic logic [31:0] scale_sample(logic [31:0] raw);
        logic [63:0] mag;
        logic [63:0] prod;
        mag = raw[31] ? {32'd0, (~raw + 32'd1)} : {32'd0, raw};
        prod = ({32'd0, gain_cfg} * mag) >> 16;
        if (raw[31])
            return (prod >= 64'h80000000) ? 32'h80000000 : (~prod[31:0] + 32'd1);
        return (prod > 64'h7FFFFFFF) ? 32'h7FFFFFFF : prod[31:0];
    endfunction

    function automatic void close_record();
        if (hdr_pending)
            push_result(KIND_CLOSE, '0, rec_count, 1'b1, hdr_time, hdr_corr, hdr_qual);
        else if (rec_count != 0)
            push_result(KIND_CLOSE, '0, rec_count, 1'b0, '0, '0, '0);
        rec_count = 0;
        hdr_pending = 1'b0;
    endfunction

    function automatic void store_sample(logic [31:0] v);
        rec_count++;
        push_result(KIND_STORE, v, rec_count, 1'b0, '0, '0, '0);
        if (rec_count >= BLOCK_SAMPLES)
            close_record();
    endfunction

    function automatic void release_zeros();
        while (held_zeros != 0)
        begin
            held_zeros--;
            store_sample('0);
        end
    endfunction

    function automatic void flush_record();
        if (suppression_on() && held_zeros <= zero_limit())
            release_zeros();
        if (rec_count != 0)
            close_record();
    endfunction

    function automatic void admit_sample(logic [31:0] raw);
        logic [31:0] v;
        v = gain_cfg[31] ? raw : scale_sample(raw);
        if (suppression_on())
        begin
            if (v == 0)
            begin
                if (held_zeros != '1)
                    held_zeros++;
                return;
            end
            if (held_zeros > zero_limit())
            begin
                close_record();
                push_result(KIND_GAP, '0, held_zeros, 1'b0, '0, hdr_corr, hdr_qual);
                held_zeros = '0;
            end
            else
                release_zeros();
        end
        store_sample(v);
    endfunction

    // Work out the results of one accepted request and queue them
    function automatic void predict_request(logic [1:0] o, logic [31:0] s, logic [63:0] t,
                                            logic [31:0] c, logic [6:0] q);
        framer_result_t r;
        step_results.delete();
        case (o)
            OP_SAMPLE:
                admit_sample(s);
            OP_MARK:
            begin
                flush_record();
                held_zeros = '0;
                hdr_time = t;
                hdr_corr = c;
                hdr_qual = q;
                hdr_pending = 1'b1;
            end
            OP_FLUSH:
                flush_record();
            default:
            begin
                flush_record();
                push_result(KIND_STREAM, '0, '0, 1'b0, '0, '0, '0);
            end
        endcase
        if (step_results.size() > 0)
        begin
            r = step_results.pop_back();
            r.lst = 1'b1;
            step_results.push_back(r);
        end
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endfunction

    // ---------------------------------------------------------------- drivers

    // Send one request; the sender idles between bursts of random length
    task automatic send_request(logic [1:0] o, logic [31:0] s, logic [63:0] t,
                                logic [31:0] c, logic [6:0] q);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= o;
        sample_value <= s;
        mark_time_in <= t;
        usec_correction_in <= c;
        quality_in <= q;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        predict_request(o, s, t, c, q);
        requests_sent++;
    endtask

    task automatic send_sample(logic [31:0] s);
        send_request(OP_SAMPLE, s, {$urandom, $urandom}, $urandom, 7'($urandom));
    endtask

    task automatic send_op(logic [1:0] o);
        send_request(o, $urandom, {$urandom, $urandom}, $urandom, 7'($urandom));
    endtask

    task automatic send_mark(logic [63:0] t, logic [31:0] c, logic [6:0] q);
        send_request(OP_MARK, $urandom, t, c, q);
    endtask

    task automatic send_zeros(int n);
        repeat (n) send_sample('0);
    endtask

    // Hold off until every expected result is out and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Present one register write and wait for it to be taken; valid stays up
    task automatic write_register(logic idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        if (idx == CFG_MAX_ZERO_RUN)
            run_limit_cfg = data[6:0];
        else
            gain_cfg = data;
    endtask

    // Upper bits of the zero-run write are junk the block must ignore
    task automatic set_config(logic [6:0] limit, logic [31:0] gain);
        logic [31:0] junk;
        junk = $urandom;
        drain();
        write_register(CFG_MAX_ZERO_RUN, {junk[31:7], limit});
        write_register(CFG_SCALE_FACTOR, gain);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // Every request type at reset settings: no gain, no suppression
    task automatic test_request_types();
        send_sample('0);
        send_sample(32'h7FFFFFFF);
        send_sample(32'h80000000);
        send_sample(32'hFFFFFFFF);
        send_op(OP_FLUSH);
        // quality above 100 is kept as given
        send_mark('1, 32'h80000000, 7'd127);
        send_sample(32'd5);
        send_op(OP_FLUSH);
        send_mark('0, '0, '0);
        // pending header with an empty record does not close on a flush
        send_op(OP_STREAM);
        send_op(OP_FLUSH);
        send_mark({$urandom, $urandom}, 32'h7FFFFFFF, 7'd100);
        send_mark({$urandom, $urandom}, $urandom, 7'($urandom));
        send_sample(32'd1);
        send_op(OP_STREAM);
    endtask

    // Gain extremes: unity, saturation, truncation toward zero, zero, bypass
    task automatic test_scaling();
        set_config(7'h7F, 32'h00010000);
        send_sample(32'h7FFFFFFF);
        send_sample(32'h80000000);
        send_sample(32'hFFFFFFFF);
        send_sample(32'd1);
        set_config(7'h7F, 32'h7FFFFFFF);
        send_sample(32'h7FFFFFFF);
        send_sample(32'h80000000);
        send_sample(32'd2);
        send_sample(32'hFFFFFFFE);
        set_config(7'h7F, 32'h00008000);
        send_sample(32'd3);
        send_sample(32'hFFFFFFFD);
        send_sample(32'hFFFFFFFF);
        set_config(7'h7F, 32'h00000000);
        send_sample($urandom);
        set_config(7'h7F, 32'h80000000);
        send_sample($urandom);
        send_op(OP_FLUSH);
    endtask

    // Held zeros: release, gap, flush and timemark behavior, limit clamping
    task automatic test_zero_runs();
        set_config(7'd3, 32'hFFFF0000);
        send_zeros(3);
        send_sample(32'd7);
        send_zeros(4);
        send_sample(32'd7);
        send_zeros(2);
        send_op(OP_FLUSH);
        // over-limit run survives a flush and later turns into a gap
        send_zeros(5);
        send_op(OP_FLUSH);
        send_zeros(1);
        send_sample(32'd9);
        // gap closes a record that holds only a header
        send_mark({$urandom, $urandom}, $urandom, 7'd42);
        send_zeros(5);
        send_sample(32'd9);
        send_zeros(2);
        send_mark({$urandom, $urandom}, $urandom, 7'd17);
        send_zeros(6);
        send_mark({$urandom, $urandom}, $urandom, 7'd99);
        send_sample(32'd8);
        set_config(7'd0, 32'hFFFF0000);
        send_zeros(1);
        send_sample(32'd8);
        // limit above the cap behaves as the cap
        set_config(7'd63, 32'hFFFF0000);
        send_zeros(48);
        send_sample(32'd8);
        send_zeros(49);
        send_sample(32'd8);
        // most negative limit disables suppression
        set_config(7'h40, 32'hFFFF0000);
        send_zeros(2);
        send_op(OP_FLUSH);
    endtask

    // Zeros held while suppression is off are neither counted nor released
    task automatic test_suppression_toggle();
        set_config(7'd4, 32'hFFFF0000);
        send_zeros(3);
        set_config(7'h7F, 32'hFFFF0000);
        send_sample('0);
        send_sample(32'd5);
        set_config(7'd4, 32'hFFFF0000);
        send_zeros(1);
        send_sample(32'd6);
        send_op(OP_FLUSH);
    endtask

    // Fill a record past its size, with released zeros crossing the boundary
    task automatic test_full_record();
        set_config(7'd48, 32'hFFFF0000);
        repeat (BLOCK_SAMPLES - 12) send_sample($urandom | 32'd1);
        send_zeros(20);
        send_sample(32'd3);
        repeat (10) send_sample($urandom | 32'd1);
        send_op(OP_FLUSH);
    endtask

    task automatic test_random_traffic();
        logic [6:0]  limit;
        logic [31:0] gain;
        logic [31:0] v;
        int          sent;
        int          pick;
        int          run;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0: limit = 7'h7F;
                1: limit = 7'($urandom_range(0, 10));
                2: limit = 7'($urandom_range(0, 63));
                default: limit = 7'h40 | 7'($urandom_range(0, 63));
            endcase
            case ($urandom_range(0, 3))
                0: gain = $urandom | 32'h80000000;
                1: gain = 32'h00010000;
                2: gain = $urandom_range(0, 32'h30000);
                default: gain = $urandom & 32'h7FFFFFFF;
            endcase
            // first two phases pin the register extremes
            if (phase == 0)
                set_config(7'd63, 32'h7FFFFFFF);
            else if (phase == 1)
                set_config(7'h40, 32'h80000000);
            else
                set_config(limit, gain);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 14)
                begin
                    run = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 56);
                    send_zeros(run);
                    sent += run;
                end
                else
                begin
                    if (pick < 72)
                    begin
                        case ($urandom_range(0, 4))
                            0: v = $urandom;
                            1: v = $urandom_range(0, 40) - 20;
                            2: v = $urandom >> $urandom_range(0, 31);
                            3: v = '0;
                            default:
                                case ($urandom_range(0, 3))
                                    0: v = 32'h7FFFFFFF;
                                    1: v = 32'h80000000;
                                    2: v = 32'hFFFFFFFF;
                                    default: v = 32'd1;
                                endcase
                        endcase
                        send_sample(v);
                    end
                    else if (pick < 84)
                        send_mark({$urandom, $urandom}, $urandom, 7'($urandom_range(0, 127)));
                    else if (pick < 93)
                        send_op(OP_FLUSH);
                    else
                        send_op(OP_STREAM);
                    sent++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- receiver

    // Stall pattern: free-running, scattered stalls, or long stall runs
    always @(posedge clk)
    begin
        logic nxt;
        if (stall_mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(20, 200);
        end
        stall_mode_left--;
        case (stall_mode)
            0: nxt = 1'b0;
            1: nxt = ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run > 0)
                begin
                    stall_run--;
                    nxt = 1'b1;
                end
                else if ($urandom_range(0, 5) == 0)
                begin
                    stall_run = $urandom_range(2, 10);
                    nxt = 1'b1;
                end
                else
                    nxt = 1'b0;
            end
        endcase
        out_stall <= nxt;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        framer_result_t got;
        framer_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind: kind, smp: sample_out, cnt: count_out, has: has_time,
                    tm: time_out, corr: correction_out, qual: quality_out, lst: last};
            if (expected_results.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected result: kind=%0d sample=%0d count=%0d last=%0d",
                             got.kind, $signed(got.smp), got.cnt, got.lst);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.kind !== want.kind || got.smp !== want.smp || got.cnt !== want.cnt ||
                    got.has !== want.has || got.tm !== want.tm || got.corr !== want.corr ||
                    got.qual !== want.qual || got.lst !== want.lst)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                    begin
                        $display("mismatch on result %0d", results_checked);
                        $display("  expected kind=%0d sample=%0d count=%0d has=%0d time=%h",
                                 want.kind, $signed(want.smp), want.cnt, want.has, want.tm);
                        $display("           corr=%0d qual=%0d last=%0d",
                                 $signed(want.corr), want.qual, want.lst);
                        $display("  actual   kind=%0d sample=%0d count=%0d has=%0d time=%h",
                                 got.kind, $signed(got.smp), got.cnt, got.has, got.tm);
                        $display("           corr=%0d qual=%0d last=%0d",
                                 $signed(got.corr), got.qual, got.lst);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: nothing accepted for %0d cycles, %0d results still due",
                     idle_cycles, expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_types();
        test_scaling();
        test_zero_runs();
        test_suppression_toggle();
        test_full_record();
        test_random_traffic();
        drain();
        $display("Covered request types, gain extremes, zero holding, a full record and %0d",
                 RANDOM_PHASES);
        $display("random phases: %0d requests sent, %0d results checked",
                 requests_sent, results_checked);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
        begin
            $display("%0d mismatches, %0d unexpected, %0d missing results",
                     mismatch_count, unexpected_count, expected_results.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
